FILE: design/swdm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swdm_pkg
// Shared types and constants of the serial wire debug master pin engine.
// ----------------------------------------------------------------------------
package swdm_pkg;

   localparam logic [1:0] OP_START   = 2'd0;
   localparam logic [1:0] OP_TICK    = 2'd1;
   localparam logic [1:0] OP_CONNECT = 2'd2;

   localparam logic [2:0] CSR_MAX_ATTEMPTS = 3'd0;
   localparam logic [2:0] CSR_RETRY_IDLE   = 3'd1;
   localparam logic [2:0] CSR_FAULT_BUDGET = 3'd2;
   localparam logic [2:0] CSR_ABORT_WORD   = 3'd3;
   localparam logic [2:0] CSR_RESET_HIGH   = 3'd4;
   localparam logic [2:0] CSR_RESET_IDLE   = 3'd5;

   localparam logic [2:0]  ACK_OK      = 3'd1;
   localparam logic [2:0]  ACK_WAIT    = 3'd2;
   localparam logic [2:0]  ACK_FAULT   = 3'd4;
   localparam logic [15:0] SWITCH_WORD = 16'hE79E;
   localparam logic [7:0]  MIN_HIGH    = 8'd50;
   localparam logic [3:0]  MIN_IDLE    = 4'd2;

   typedef struct packed {
      logic [1:0]  opcode;
      logic        ap_not_dp;
      logic        read_not_write;
      logic [1:0]  reg_addr;
      logic [31:0] write_data;
      logic        swdio_sampled;
   } cmd_type;

   typedef struct packed {
      logic        clock_cycle;
      logic        swdio_level;
      logic        swdio_enable;
      logic        done_res;
      logic [2:0]  final_ack;
      logic [31:0] read_word;
   } res_type;

   typedef struct packed {
      logic [3:0]  max_attempts;
      logic [3:0]  retry_idle_clocks;
      logic [1:0]  fault_recovery_budget;
      logic [31:0] abort_word;
      logic [7:0]  reset_high_clocks;
      logic [3:0]  reset_idle_clocks;
   } cfg_type;

endpackage
`default_nettype wire

FILE: design/swdm_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swdm_front
// Input stage: a two-entry queue of command words toward the
// pin sequencer, so both sides stall independently.
// ----------------------------------------------------------------------------
module swdm_front (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    in_valid,
   output logic                   in_ready,
   input  wire  swdm_pkg::cmd_type in_cmd,
   output logic                   out_valid,
   input  wire                    out_ready,
   output swdm_pkg::cmd_type      out_cmd
);
   import swdm_pkg::*;

   cmd_type    q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_cmd   = q_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (push) q_ff[wr_ptr_ff] <= in_cmd;
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd2 |-> !in_ready) else $error("queue overflow");
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3) else $error("bad count");
   a_pop_moves: assert property (@(posedge clock) disable iff (reset)
      pop && !push |=> cnt_ff == $past(cnt_ff) - 2'd1) else $error("pop lost");
`endif

endmodule
`default_nettype wire

FILE: design/swdm_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swdm_back
// Pin sequencer: runs one command a cycle through the SWD phase machine while
// the output is not stalled, and holds its result in an output register.
// ----------------------------------------------------------------------------
module swdm_back (
   input  wire                    clock,
   input  wire                    reset,
   input  wire  swdm_pkg::cfg_type cfg,
   input  wire                    in_valid,
   output logic                   in_ready,
   input  wire  swdm_pkg::cmd_type in_cmd,
   output logic                   out_valid,
   input  wire                    out_ready,
   output swdm_pkg::res_type      out_res
);
   import swdm_pkg::*;

   localparam logic [3:0] PH_IDLE = 4'd0, PH_REQ = 4'd1, PH_ACK = 4'd2,
      PH_RDATA = 4'd3, PH_RPAR = 4'd4, PH_RTRN = 4'd5, PH_WTRN = 4'd6,
      PH_WDATA = 4'd7, PH_WPB = 4'd8, PH_WPAR = 4'd9, PH_RETRY = 4'd10,
      PH_CH1 = 4'd11, PH_CL1 = 4'd12, PH_CSW = 4'd13, PH_CH2 = 4'd14,
      PH_CL2 = 4'd15;

   logic [3:0]  phase_ff, phase_in;
   logic [7:0]  cnt_ff, cnt_in;
   logic [31:0] shift_ff, shift_in;
   logic [7:0]  reqb_ff, reqb_in;
   logic [2:0]  ack_ff, ack_in;
   logic        sap_ff, sap_in, srnw_ff, srnw_in;
   logic [1:0]  saddr_ff, saddr_in;
   logic [31:0] sdata_ff, sdata_in;
   logic [3:0]  att_ff, att_in;
   logic [1:0]  flt_ff, flt_in;
   logic        abt_ff, abt_in;
   logic [31:0] rres_ff, rres_in;
   logic        ov_ff, ov_in;
   res_type     res_ff, res_in;

   logic        step, clk, lvl, en, done;
   logic [2:0]  ack;
   logic [7:0]  hi_lim, cnt_inc;
   logic [3:0]  lo_lim;

   function automatic logic [7:0] make_req(logic ap, logic rnw, logic [1:0] a);
      return {1'b1, 1'b0, ap ^ rnw ^ a[0] ^ a[1], a[1], a[0], rnw, ap, 1'b1};
   endfunction

   assign in_ready  = !ov_ff || out_ready;
   assign step      = in_valid && in_ready;
   assign out_valid = ov_ff;
   assign out_res   = res_ff;
   assign hi_lim    = (cfg.reset_high_clocks < MIN_HIGH) ? MIN_HIGH : cfg.reset_high_clocks;
   assign lo_lim    = (cfg.reset_idle_clocks < MIN_IDLE) ? MIN_IDLE : cfg.reset_idle_clocks;
   assign cnt_inc   = cnt_ff + 8'd1;

   always_comb begin
      logic attempts_zero;
      logic [2:0] a;
      logic do_finish, do_sched, do_over, do_begin;
      phase_in = phase_ff; cnt_in = cnt_ff; shift_in = shift_ff; reqb_in = reqb_ff;
      ack_in = ack_ff; sap_in = sap_ff; srnw_in = srnw_ff; saddr_in = saddr_ff;
      sdata_in = sdata_ff; att_in = att_ff; flt_in = flt_ff; abt_in = abt_ff;
      rres_in = rres_ff;
      clk = 1'b0; lvl = 1'b0; en = 1'b1; done = 1'b0; ack = 3'd0;
      do_finish = 1'b0; do_sched = 1'b0; do_over = 1'b0; do_begin = 1'b0;
      attempts_zero = 1'b0; a = ack_ff;
      if (in_cmd.opcode == OP_START && phase_ff == PH_IDLE) begin
         sdata_in = in_cmd.write_data; sap_in = in_cmd.ap_not_dp;
         srnw_in = in_cmd.read_not_write; saddr_in = in_cmd.reg_addr;
         att_in = (cfg.max_attempts == 4'd0) ? 4'd1 : cfg.max_attempts;
         flt_in = cfg.fault_recovery_budget;
         abt_in = 1'b0;
         do_begin = 1'b1;
      end else if (in_cmd.opcode == OP_CONNECT && phase_ff == PH_IDLE) begin
         phase_in = PH_CH1; cnt_in = 8'd0;
      end else if (in_cmd.opcode == OP_TICK && phase_ff != PH_IDLE) begin
         clk = 1'b1;
         case (phase_ff)
            PH_REQ: begin
               lvl = reqb_ff[cnt_ff[2:0]];
               cnt_in = cnt_inc;
               if (cnt_inc >= 8'd8) begin phase_in = PH_ACK; cnt_in = 8'd0; end
            end
            PH_ACK: begin
               en = 1'b0;
               ack_in[cnt_ff[1:0]] = ack_ff[cnt_ff[1:0]] | in_cmd.swdio_sampled;
               cnt_in = cnt_inc;
               if (cnt_inc >= 8'd3) begin
                  cnt_in = 8'd0;
                  phase_in = reqb_ff[2] ? PH_RDATA : PH_WTRN;
               end
            end
            PH_RDATA: begin
               en = 1'b0;
               shift_in[cnt_ff[4:0]] = shift_ff[cnt_ff[4:0]] | in_cmd.swdio_sampled;
               cnt_in = cnt_inc;
               if (cnt_inc >= 8'd32) begin phase_in = PH_RPAR; cnt_in = 8'd0; end
            end
            PH_RPAR: begin en = 1'b0; phase_in = PH_RTRN; end
            PH_RTRN: do_finish = 1'b1;
            PH_WTRN: begin
               en = 1'b0;
               shift_in = abt_ff ? cfg.abort_word : sdata_ff;
               cnt_in = 8'd0; phase_in = PH_WDATA;
            end
            PH_WDATA: begin
               lvl = (cnt_ff == 8'd0) ? 1'b0 : shift_ff[5'(cnt_ff - 8'd1)];
               cnt_in = cnt_inc;
               if (cnt_inc >= 8'd32) begin phase_in = PH_WPB; cnt_in = 8'd0; end
            end
            PH_WPB: begin lvl = shift_ff[31]; phase_in = PH_WPAR; end
            PH_WPAR: begin lvl = ^shift_ff; do_finish = 1'b1; end
            PH_RETRY: begin
               cnt_in = cnt_inc;
               if (cnt_inc >= {4'd0, cfg.retry_idle_clocks}) do_over = 1'b1;
            end
            PH_CH1, PH_CH2: begin
               lvl = 1'b1; cnt_in = cnt_inc;
               if (cnt_inc >= hi_lim) begin phase_in = phase_ff + 4'd1; cnt_in = 8'd0; end
            end
            PH_CL1: begin
               cnt_in = cnt_inc;
               if (cnt_inc >= {4'd0, lo_lim}) begin phase_in = PH_CSW; cnt_in = 8'd0; end
            end
            PH_CSW: begin
               lvl = SWITCH_WORD[cnt_ff[3:0]]; cnt_in = cnt_inc;
               if (cnt_inc >= 8'd16) begin phase_in = PH_CH2; cnt_in = 8'd0; end
            end
            default: begin
               cnt_in = cnt_inc;
               if (cnt_inc >= {4'd0, lo_lim}) begin
                  phase_in = PH_IDLE; cnt_in = 8'd0; done = 1'b1;
               end
            end
         endcase
         if (do_finish) begin
            if (abt_ff) begin
               abt_in = 1'b0; do_sched = 1'b1;
            end else begin
               if (att_ff != 4'd0) att_in = att_ff - 4'd1;
               if (a == ACK_OK) begin
                  if (reqb_ff[2]) rres_in = shift_ff;
                  phase_in = PH_IDLE; done = 1'b1; ack = ACK_OK;
               end else if (a == ACK_FAULT && flt_ff != 2'd0) begin
                  flt_in = flt_ff - 2'd1; abt_in = 1'b1; do_begin = 1'b1;
               end else if (a == ACK_WAIT) begin
                  do_sched = 1'b1;
               end else begin
                  phase_in = PH_IDLE; done = 1'b1; ack = a;
               end
            end
         end
         if (do_sched) begin
            if (cfg.retry_idle_clocks != 4'd0) begin
               phase_in = PH_RETRY; cnt_in = 8'd0;
            end else do_over = 1'b1;
         end
         if (do_over) begin
            attempts_zero = (att_in == 4'd0);
            if (attempts_zero) begin
               phase_in = PH_IDLE; done = 1'b1; ack = ACK_WAIT;
            end else do_begin = 1'b1;
         end
      end
      if (do_begin) begin
         phase_in = PH_REQ; cnt_in = 8'd0; ack_in = 3'd0; shift_in = 32'd0;
         reqb_in = abt_in ? make_req(1'b0, 1'b0, 2'd0) : make_req(sap_in, srnw_in, saddr_in);
      end
      res_in.clock_cycle = clk; res_in.swdio_level = lvl; res_in.swdio_enable = en;
      res_in.done_res = done; res_in.final_ack = ack; res_in.read_word = rres_in;
      ov_in = step ? 1'b1 : (out_ready ? 1'b0 : ov_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE; cnt_ff <= 8'd0; shift_ff <= 32'd0; reqb_ff <= 8'd0;
         ack_ff <= 3'd0; sap_ff <= 1'b0; srnw_ff <= 1'b0; saddr_ff <= 2'd0;
         sdata_ff <= 32'd0; att_ff <= 4'd0; flt_ff <= 2'd0; abt_ff <= 1'b0;
         rres_ff <= 32'd0; ov_ff <= 1'b0;
      end else begin
         ov_ff <= ov_in;
         if (step) begin
            phase_ff <= phase_in; cnt_ff <= cnt_in; shift_ff <= shift_in;
            reqb_ff <= reqb_in; ack_ff <= ack_in; sap_ff <= sap_in; srnw_ff <= srnw_in;
            saddr_ff <= saddr_in; sdata_ff <= sdata_in; att_ff <= att_in;
            flt_ff <= flt_in; abt_ff <= abt_in; rres_ff <= rres_in;
         end
      end
      if (step) res_ff <= res_in;
   end

`ifndef SYNTHESIS
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      step && done |=> phase_ff == PH_IDLE) else $error("done without idle");
   a_hold_stall: assert property (@(posedge clock) disable iff (reset)
      ov_ff && !out_ready |=> ov_ff && $stable(res_ff)) else $error("result lost");
   a_released: assert property (@(posedge clock) disable iff (reset)
      ov_ff && !res_ff.swdio_enable |-> !res_ff.swdio_level) else $error("level on release");
   a_ack_done: assert property (@(posedge clock) disable iff (reset)
      ov_ff && res_ff.final_ack != 3'd0 |-> res_ff.done_res) else $error("stray ack");
`endif

endmodule
`default_nettype wire

FILE: design/swd_master_transaction_engine_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swd_master_transaction_engine_core
// Serial wire debug master pin engine: one command word in, one pin word out.
// ----------------------------------------------------------------------------
// channel | direction | contents
// req_    | in        | command word: opcode, target, data, sampled SWDIO
// rsp_    | out       | pin word: clock, level, enable, done, ack, read data
// csr_    | in        | register writes, index 0..5
// One word per cycle unless a side stalls; each word passes the queue, then
// the sequencer output register. The sequencer step is the rate-setting loop.
// Synchronous reset clears all control state and loads register defaults.
// Either side may stall; the two-entry queue and output register absorb it.
// ----------------------------------------------------------------------------
module swd_master_transaction_engine_core (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   // [1:0] opcode, [2] ap_not_dp, [3] read_not_write, [5:4] reg_addr,
   // [37:6] write_data, [38] swdio_sampled, [39] zero
   input  wire  [39:0] req_tdata,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // [0] clock_cycle, [1] swdio_level, [2] swdio_enable, [3] done_res,
   // [6:4] final_ack, [38:7] read_word, [39] zero
   output logic [39:0] rsp_tdata,
   input  wire         csr_we,
   input  wire  [2:0]  csr_addr,
   input  wire  [31:0] csr_wdata
);
   import swdm_pkg::*;

   cfg_type cfg_ff;
   cmd_type in_cmd, q_cmd;
   res_type res;
   logic    q_valid, q_ready;

   assign in_cmd.opcode         = req_tdata[1:0];
   assign in_cmd.ap_not_dp      = req_tdata[2];
   assign in_cmd.read_not_write = req_tdata[3];
   assign in_cmd.reg_addr       = req_tdata[5:4];
   assign in_cmd.write_data     = req_tdata[37:6];
   assign in_cmd.swdio_sampled  = req_tdata[38];

   assign rsp_tdata = {1'b0, res.read_word, res.final_ack, res.done_res,
                       res.swdio_enable, res.swdio_level, res.clock_cycle};

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_attempts          <= 4'd8;
         cfg_ff.retry_idle_clocks     <= 4'd4;
         cfg_ff.fault_recovery_budget <= 2'd1;
         cfg_ff.abort_word            <= 32'h0000_001E;
         cfg_ff.reset_high_clocks     <= 8'd60;
         cfg_ff.reset_idle_clocks     <= 4'd4;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_MAX_ATTEMPTS: cfg_ff.max_attempts          <= csr_wdata[3:0];
            CSR_RETRY_IDLE:   cfg_ff.retry_idle_clocks     <= csr_wdata[3:0];
            CSR_FAULT_BUDGET: cfg_ff.fault_recovery_budget <= csr_wdata[1:0];
            CSR_ABORT_WORD:   cfg_ff.abort_word            <= csr_wdata;
            CSR_RESET_HIGH:   cfg_ff.reset_high_clocks     <= csr_wdata[7:0];
            CSR_RESET_IDLE:   cfg_ff.reset_idle_clocks     <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   swdm_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready), .in_cmd(in_cmd),
      .out_valid(q_valid), .out_ready(q_ready), .out_cmd(q_cmd)
   );

   swdm_back u_back (
      .clock(clock), .reset(reset), .cfg(cfg_ff),
      .in_valid(q_valid), .in_ready(q_ready), .in_cmd(q_cmd),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_res(res)
   );

endmodule
`default_nettype wire

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the serial wire debug master pin engine. Command
// words go in on the req_ stream and pin words come back on the rsp_ stream.
// A local model of the sequencer predicts the pin words, save for typed rows
// of the directed table. Stimulus opens with a short directed table and then
// runs random transactions and connect sequences. Both streams idle at random,
// and the registers are reloaded between phases while the engine is idle.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import swdm_pkg::*;

   typedef enum logic [3:0] {
      SQ_IDLE, SQ_REQ, SQ_ACK, SQ_RDATA, SQ_RPAR, SQ_RTRN, SQ_WTRN, SQ_WDATA,
      SQ_WPB, SQ_WPAR, SQ_RETRY, SQ_CH1, SQ_CL1, SQ_CSW, SQ_CH2, SQ_CL2
   } seq_phase_type;

   typedef struct {
      logic [1:0]  op;
      logic        ap;
      logic        rnw;
      logic [1:0]  addr;
      logic [31:0] data;
      logic        sdio;
      int          reps;
      bit          typed;
      res_type     pins;
   } stim_row_type;

   localparam int ITEM_TARGET = 1450;

   logic        clock, reset;
   logic        req_tvalid, req_tready, rsp_tvalid, rsp_tready;
   logic [39:0] req_tdata, rsp_tdata;
   logic        csr_we;
   logic [2:0]  csr_addr;
   logic [31:0] csr_wdata;

   // register copy
   logic [3:0]  r_attempts, r_retry_idle, r_reset_idle;
   logic [1:0]  r_fault_budget;
   logic [31:0] r_abort_word;
   logic [7:0]  r_reset_high;

   // sequencer copy
   seq_phase_type ph;
   int          bits;
   logic [31:0] shifter, rd_result;
   logic [7:0]  req_byte;
   logic [2:0]  ack_acc;
   logic        cmd_ap, cmd_rnw, aborting;
   logic [1:0]  cmd_addr;
   logic [31:0] cmd_data;
   logic [3:0]  attempts_left;
   logic [1:0]  faults_left;
   logic        out_done;
   logic [2:0]  out_ack;

   res_type     expected_pins[$];
   int          errors = 0;
   int          items = 0;
   bit          calm = 0;

   swd_master_transaction_engine_core DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("DONE: errors detected");
      $finish;
   end

   function automatic logic [7:0] request_for(logic ap, logic rnw, logic [1:0] addr);
      logic p;
      p = ap ^ rnw ^ addr[0] ^ addr[1];
      return {1'b1, 1'b0, p, addr[1], addr[0], rnw, ap, 1'b1};
   endfunction

   function void begin_attempt();
      ph = SQ_REQ;
      bits = 0;
      ack_acc = '0;
      shifter = '0;
      req_byte = aborting ? request_for(1'b0, 1'b0, 2'd0)
                          : request_for(cmd_ap, cmd_rnw, cmd_addr);
   endfunction

   function void retry_over();
      if (attempts_left == 0) begin
         ph = SQ_IDLE;
         out_done = 1;
         out_ack = ACK_WAIT;
      end else begin
         begin_attempt();
      end
   endfunction

   function void schedule_retry();
      if (r_retry_idle > 0) begin
         ph = SQ_RETRY;
         bits = 0;
      end else begin
         retry_over();
      end
   endfunction

   function void finish_attempt();
      if (aborting) begin
         aborting = 0;
         schedule_retry();
         return;
      end
      if (attempts_left > 0) attempts_left--;
      if (ack_acc == ACK_OK) begin
         if (req_byte[2]) rd_result = shifter;
         ph = SQ_IDLE;
         out_done = 1;
         out_ack = ACK_OK;
      end else if (ack_acc == ACK_FAULT && faults_left > 0) begin
         faults_left--;
         aborting = 1;
         begin_attempt();
      end else if (ack_acc == ACK_WAIT) begin
         schedule_retry();
      end else begin
         ph = SQ_IDLE;
         out_done = 1;
         out_ack = ack_acc;
      end
   endfunction

   // advance the sequencer copy by one command word, return the pin word
   function res_type step_pins(cmd_type c);
      res_type r;
      int hi_lim, lo_lim;
      hi_lim = r_reset_high < MIN_HIGH ? MIN_HIGH : r_reset_high;
      lo_lim = r_reset_idle < MIN_IDLE ? MIN_IDLE : r_reset_idle;
      r = '0;
      r.swdio_enable = 1;
      out_done = 0;
      out_ack = '0;
      if (c.opcode == OP_START && ph == SQ_IDLE) begin
         cmd_data = c.write_data;
         cmd_ap = c.ap_not_dp;
         cmd_rnw = c.read_not_write;
         cmd_addr = c.reg_addr;
         attempts_left = r_attempts == 0 ? 4'd1 : r_attempts;
         faults_left = r_fault_budget;
         aborting = 0;
         begin_attempt();
      end else if (c.opcode == OP_CONNECT && ph == SQ_IDLE) begin
         ph = SQ_CH1;
         bits = 0;
      end else if (c.opcode == OP_TICK && ph != SQ_IDLE) begin
         r.clock_cycle = 1;
         case (ph)
            SQ_REQ: begin
               r.swdio_level = req_byte[bits];
               if (++bits >= 8) begin ph = SQ_ACK; bits = 0; end
            end
            SQ_ACK: begin
               r.swdio_enable = 0;
               ack_acc[bits] = c.swdio_sampled;
               if (++bits >= 3) begin
                  bits = 0;
                  ph = req_byte[2] ? SQ_RDATA : SQ_WTRN;
               end
            end
            SQ_RDATA: begin
               r.swdio_enable = 0;
               shifter[bits] = c.swdio_sampled;
               if (++bits >= 32) begin ph = SQ_RPAR; bits = 0; end
            end
            SQ_RPAR: begin
               r.swdio_enable = 0;
               ph = SQ_RTRN;
            end
            SQ_RTRN: finish_attempt();
            SQ_WTRN: begin
               r.swdio_enable = 0;
               shifter = aborting ? r_abort_word : cmd_data;
               bits = 0;
               ph = SQ_WDATA;
            end
            SQ_WDATA: begin
               r.swdio_level = bits == 0 ? 1'b0 : shifter[bits - 1];
               if (++bits >= 32) begin ph = SQ_WPB; bits = 0; end
            end
            SQ_WPB: begin
               r.swdio_level = shifter[31];
               ph = SQ_WPAR;
            end
            SQ_WPAR: begin
               r.swdio_level = ^shifter;
               finish_attempt();
            end
            SQ_RETRY: if (++bits >= r_retry_idle) retry_over();
            SQ_CH1, SQ_CH2: begin
               r.swdio_level = 1;
               if (++bits >= hi_lim) begin ph = seq_phase_type'(ph + 1); bits = 0; end
            end
            SQ_CL1: if (++bits >= lo_lim) begin ph = SQ_CSW; bits = 0; end
            SQ_CSW: begin
               r.swdio_level = SWITCH_WORD[bits];
               if (++bits >= 16) begin ph = SQ_CH2; bits = 0; end
            end
            default: if (++bits >= lo_lim) begin ph = SQ_IDLE; bits = 0; out_done = 1; end
         endcase
      end
      r.done_res = out_done;
      r.final_ack = out_ack;
      r.read_word = rd_result;
      return r;
   endfunction

   task automatic write_reg(logic [2:0] idx, logic [31:0] val);
      @(posedge clock);
      csr_we <= 1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 0;
      case (idx)
         CSR_MAX_ATTEMPTS: r_attempts = val[3:0];
         CSR_RETRY_IDLE:   r_retry_idle = val[3:0];
         CSR_FAULT_BUDGET: r_fault_budget = val[1:0];
         CSR_ABORT_WORD:   r_abort_word = val;
         CSR_RESET_HIGH:   r_reset_high = val[7:0];
         CSR_RESET_IDLE:   r_reset_idle = val[3:0];
         default: ;
      endcase
   endtask

   task automatic drain();
      wait (expected_pins.size() == 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic load_regs(logic [3:0] att, logic [3:0] ri, logic [1:0] fb,
                            logic [31:0] aw, logic [7:0] rh, logic [3:0] rl);
      drain();
      write_reg(CSR_MAX_ATTEMPTS, att);
      write_reg(CSR_RETRY_IDLE, ri);
      write_reg(CSR_FAULT_BUDGET, fb);
      write_reg(CSR_ABORT_WORD, aw);
      write_reg(CSR_RESET_HIGH, rh);
      write_reg(CSR_RESET_IDLE, rl);
   endtask

   // hold the word until taken, then update the model
   task automatic send(cmd_type c, bit typed = 0, res_type pins = '0);
      bit taken;
      res_type p;
      req_tvalid <= 1;
      req_tdata <= {1'b0, c.swdio_sampled, c.write_data, c.reg_addr,
                    c.read_not_write, c.ap_not_dp, c.opcode};
      do begin
         @(negedge clock);
         taken = req_tready;
         @(posedge clock);
      end while (!taken);
      p = step_pins(c);
      expected_pins.push_back(typed ? pins : p);
      items++;
      if (!calm && $urandom_range(99) < 24) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   function automatic cmd_type make_cmd(logic [1:0] op, logic sdio);
      cmd_type c;
      c.opcode = op;
      c.ap_not_dp = $urandom_range(1);
      c.read_not_write = $urandom_range(1);
      c.reg_addr = $urandom_range(3);
      c.write_data = $urandom;
      c.swdio_sampled = sdio;
      return c;
   endfunction

   // pick the target's answer for one attempt
   function automatic logic [2:0] pick_ack();
      int k;
      k = $urandom_range(99);
      if (k < 50) return ACK_OK;
      if (k < 70) return ACK_WAIT;
      if (k < 85) return ACK_FAULT;
      return $urandom_range(7);
   endfunction

   task automatic run_sequence();
      cmd_type c;
      logic [2:0] answer;
      answer = ACK_OK;
      c = make_cmd($urandom_range(99) < 10 ? OP_CONNECT : OP_START, $urandom_range(1));
      send(c);
      while (ph != SQ_IDLE) begin
         if (ph == SQ_ACK && bits == 0) answer = pick_ack();
         c = make_cmd(OP_TICK, ph == SQ_ACK ? answer[bits] : $urandom_range(1));
         // noise: busy starts, unused opcode
         if ($urandom_range(99) < 4) c.opcode = $urandom_range(3);
         send(c);
      end
   endtask

   stim_row_type plan[$];
   res_type idle_word;

   initial begin
      stim_row_type row;
      cmd_type c;
      reset = 1;
      req_tvalid = 0;
      req_tdata = '0;
      csr_we = 0;
      csr_addr = '0;
      csr_wdata = '0;
      r_attempts = 8;
      r_retry_idle = 4;
      r_fault_budget = 1;
      r_abort_word = 32'h1E;
      r_reset_high = 60;
      r_reset_idle = 4;
      ph = SQ_IDLE;
      bits = 0;
      shifter = '0;
      rd_result = '0;
      req_byte = '0;
      ack_acc = '0;
      {cmd_ap, cmd_rnw, cmd_addr, cmd_data, aborting} = '0;
      attempts_left = '0;
      faults_left = '0;
      repeat (10) @(posedge clock);
      reset <= 0;

      idle_word = '0;
      idle_word.swdio_enable = 1;
      // op, ap, rnw, addr, data, sdio, reps, typed, pins
      plan = '{
         '{OP_TICK, 1, 1, 3, '1, 1, 1, 1, idle_word},
         '{2'd3, 1, 1, 3, '1, 1, 1, 1, idle_word},
         '{OP_START, 1, 0, 3, 32'hFFFFFFFF, 0, 1, 1, idle_word},
         '{OP_CONNECT, 0, 0, 0, 0, 0, 1, 0, '0},
         '{OP_TICK, 0, 0, 0, 0, 0, 8, 0, '0},
         '{OP_TICK, 0, 0, 0, 0, 1, 1, 0, '0},
         '{OP_TICK, 0, 0, 0, 0, 0, 2, 0, '0},
         '{OP_TICK, 0, 0, 0, 0, 1, 35, 0, '0},
         '{OP_START, 0, 1, 0, 0, 0, 1, 1, idle_word},
         '{OP_TICK, 0, 0, 0, 0, 0, 8, 0, '0},
         '{OP_TICK, 0, 0, 0, 0, 1, 1, 0, '0},
         '{OP_TICK, 0, 0, 0, 0, 0, 2, 0, '0},
         '{OP_TICK, 0, 0, 0, 0, 1, 34, 0, '0},
         '{OP_START, 1, 1, 2, 0, 0, 1, 0, '0},
         '{OP_TICK, 0, 0, 0, 0, 1, 48, 0, '0},
         '{OP_START, 0, 0, 1, 32'h80000000, 0, 1, 0, '0},
         '{OP_TICK, 0, 0, 0, 0, 0, 8, 0, '0},
         '{OP_TICK, 0, 0, 0, 0, 1, 3, 0, '0},
         '{OP_TICK, 0, 0, 0, 0, 0, 35, 0, '0}
      };
      foreach (plan[i]) begin
         row = plan[i];
         c.opcode = row.op;
         c.ap_not_dp = row.ap;
         c.read_not_write = row.rnw;
         c.reg_addr = row.addr;
         c.write_data = row.data;
         c.swdio_sampled = row.sdio;
         for (int n = 0; n < row.reps; n++) begin
            if (row.typed) row.pins.read_word = rd_result;
            send(c, row.typed, row.pins);
         end
      end
      // finish whatever the table left running
      while (ph != SQ_IDLE) send(make_cmd(OP_TICK, $urandom_range(1)));

      for (int stage = 0; stage < 5; stage++) begin
         case (stage)
            0: ;
            1: load_regs(4'd1, 4'd0, 2'd0, 32'h0, 8'd50, 4'd2);
            2: load_regs(4'd15, 4'd15, 2'd3, 32'hFFFFFFFF, 8'd255, 4'd15);
            3: load_regs(4'd0, 4'd1, 2'd2, $urandom, 8'd10, 4'd0);
            default: load_regs($urandom_range(15), $urandom_range(15), $urandom_range(3),
                               $urandom, $urandom_range(50, 80), $urandom_range(15));
         endcase
         calm = (stage == 2);
         while (items < ITEM_TARGET * (stage + 1) / 5) run_sequence();
         req_tvalid <= 0;
      end

      wait (expected_pins.size() == 0);
      repeat (10) @(posedge clock);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // result side: random back-pressure, check each accepted word
   initial begin
      bit taken;
      res_type got, want;
      rsp_tready = 0;
      forever begin
         @(negedge clock);
         taken = rsp_tvalid && rsp_tready && !reset;
         got = {rsp_tdata[0], rsp_tdata[1], rsp_tdata[2], rsp_tdata[3],
                rsp_tdata[6:4], rsp_tdata[38:7]};
         @(posedge clock);
         if (taken) begin
            if (expected_pins.size() == 0) begin
               errors++;
               $display("%0t: unexpected word, expected none, actual %h", $time, got);
            end else begin
               want = expected_pins.pop_front();
               if (got.clock_cycle !== want.clock_cycle || got.swdio_level !== want.swdio_level
                   || got.swdio_enable !== want.swdio_enable || got.done_res !== want.done_res
                   || got.final_ack !== want.final_ack || got.read_word !== want.read_word) begin
                  errors++;
                  $display("%0t: pin word mismatch, expected %h, actual %h",
                           $time, want, got);
               end
            end
         end
         rsp_tready <= calm || $urandom_range(99) >= 24;
      end
   end

endmodule
